// File: hw/rtl/pulse_saw_sound_and_irq_counter_assert.svh
// Assertion macros for the pulse/saw sound generator.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef PULSE_SAW_SOUND_AND_IRQ_COUNTER_ASSERT_SVH
`define PULSE_SAW_SOUND_AND_IRQ_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSAW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psaw assertion failed");
// next-cycle implication
`define PSAW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psaw assertion failed");
`else
`define PSAW_ASSERT_NOW(lbl, ante, cons)
`define PSAW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/psaw_pkg.sv
// Shared types and constants for the pulse/saw sound generator.
// No dependencies.
`timescale 1ns / 1ps

package psaw_pkg;

  // opcodes of an input word
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MASK_A = 2'd0;
  localparam logic [1:0] CFG_MASK_B = 2'd1;

  // top address nibble of each register group
  localparam logic [3:0] NIB_PULSE0 = 4'h9;
  localparam logic [3:0] NIB_PULSE1 = 4'hA;
  localparam logic [3:0] NIB_SAW    = 4'hB;
  localparam logic [3:0] NIB_IRQ    = 4'hF;

  // register select codes
  localparam logic [1:0] SEL_0 = 2'd0;
  localparam logic [1:0] SEL_1 = 2'd1;
  localparam logic [1:0] SEL_2 = 2'd2;

  localparam logic [11:0] PERIOD_RESET  = 12'hFFF;
  localparam logic [15:0] DUTY_RESET    = 16'hFF00;
  localparam logic [8:0]  LINE_CYCLES   = 9'd341;
  localparam logic [8:0]  PRESCALE_STEP = 9'd3;
  localparam logic [3:0]  SAW_WRAP_STEP = 4'd14;
  localparam logic [7:0]  IRQ_COUNT_TOP = 8'hFF;

  // per-group command: one tick or a write to one of three selects
  typedef struct packed {
    logic       tick;
    logic       wr0;
    logic       wr1;
    logic       wr2;
    logic [7:0] data;
  } chan_cmd_t;

endpackage

// File: hw/rtl/psaw_if.sv
// Valid/ready channel interfaces for input and result words.
// No dependencies.
`timescale 1ns / 1ps

interface psaw_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;

  modport source (output valid, output opcode, output bus_address, output bus_data,
                  input ready);
  modport sink (input valid, input opcode, input bus_address, input bus_data,
                output ready);
endinterface

interface psaw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] audio_level;
  logic       irq_line;

  modport source (output valid, output audio_level, output irq_line, input ready);
  modport sink (input valid, input audio_level, input irq_line, output ready);
endinterface

// File: hw/rtl/pulse_saw_sound_and_irq_counter.sv
// Top level: address decode, sawtooth channel, result register.
// Depends on psaw_pkg, psaw_if, psaw_pulse, psaw_irq and the assertion header.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid/ready     opcode, bus_address, bus_data
//   out_ch    out  valid/ready     audio_level, irq_line
//   cfg_*     in   cfg_we only     cfg_index, cfg_data
//
// One word per cycle while in_ch.ready is high; its result appears in the output register the next cycle.
// All channel state updates in the cycle a word is accepted, and the result register
// captures that word's result. in_ch.ready drops only while a result is held
// and out_ch.ready is low. Synchronous reset restores all registers; no clear pass.
`timescale 1ns / 1ps
`include "pulse_saw_sound_and_irq_counter_assert.svh"

module pulse_saw_sound_and_irq_counter (
  input  logic        clk,
  input  logic        rst,
  psaw_in_if.sink     in_ch,
  psaw_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] mask_a, mask_b;
  logic        accept;
  logic        is_write;
  logic        low_write;
  logic [3:0]  nib;
  logic [1:0]  sel;
  logic        sel0, sel1, sel2;
  psaw_pkg::chan_cmd_t cmd_p0, cmd_p1, cmd_saw, cmd_irq;
  logic [3:0]  p0_level, p1_level;
  logic        pending_next;

  logic        saw_enable, saw_enable_next;
  logic [11:0] saw_period, saw_period_next;
  logic [11:0] saw_divider, saw_divider_next;
  logic [3:0]  saw_step, saw_step_next, saw_step_inc;
  logic [8:0]  saw_sum, saw_sum_next;
  logic [5:0]  saw_rate, saw_rate_next;
  logic [5:0]  saw_level, saw_level_next;
  logic [5:0]  saw_contrib;
  logic [6:0]  level_sum;

  logic        out_valid;
  logic [6:0]  out_level;
  logic        out_irq;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_a <= 16'd1;
      mask_b <= 16'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        psaw_pkg::CFG_MASK_A: mask_a <= cfg_data;
        psaw_pkg::CFG_MASK_B: mask_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // decode
  assign is_write = (in_ch.opcode == psaw_pkg::OP_WRITE) && in_ch.bus_address[15];
  assign nib      = in_ch.bus_address[15:12];
  assign sel      = {|(in_ch.bus_address & mask_b), |(in_ch.bus_address & mask_a)};
  assign sel0     = is_write && (sel == psaw_pkg::SEL_0);
  assign sel1     = is_write && (sel == psaw_pkg::SEL_1);
  assign sel2     = is_write && (sel == psaw_pkg::SEL_2);
  assign low_write = accept && (in_ch.opcode == psaw_pkg::OP_WRITE) && !in_ch.bus_address[15];

  always_comb begin
    cmd_p0  = '0;
    cmd_p1  = '0;
    cmd_saw = '0;
    cmd_irq = '0;
    cmd_p0.data  = in_ch.bus_data;
    cmd_p1.data  = in_ch.bus_data;
    cmd_saw.data = in_ch.bus_data;
    cmd_irq.data = in_ch.bus_data;
    cmd_p0.tick  = (in_ch.opcode == psaw_pkg::OP_TICK);
    cmd_p1.tick  = cmd_p0.tick;
    cmd_saw.tick = cmd_p0.tick;
    cmd_irq.tick = cmd_p0.tick;
    case (nib)
      psaw_pkg::NIB_PULSE0: begin
        cmd_p0.wr0 = sel0;
        cmd_p0.wr1 = sel1;
        cmd_p0.wr2 = sel2;
      end
      psaw_pkg::NIB_PULSE1: begin
        cmd_p1.wr0 = sel0;
        cmd_p1.wr1 = sel1;
        cmd_p1.wr2 = sel2;
      end
      psaw_pkg::NIB_SAW: begin
        cmd_saw.wr0 = sel0;
        cmd_saw.wr1 = sel1;
        cmd_saw.wr2 = sel2;
      end
      psaw_pkg::NIB_IRQ: begin
        cmd_irq.wr0 = sel0;
        cmd_irq.wr1 = sel1;
        cmd_irq.wr2 = sel2;
      end
      default: ;
    endcase
  end

  psaw_pulse u_pulse0 (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd_p0),
    .level_next_out (p0_level)
  );

  psaw_pulse u_pulse1 (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd_p1),
    .level_next_out (p1_level)
  );

  psaw_irq u_irq (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .cmd              (cmd_irq),
    .pending_next_out (pending_next)
  );

  // sawtooth channel
  assign saw_step_inc = saw_step + 4'd1;

  always_comb begin
    saw_enable_next  = saw_enable;
    saw_period_next  = saw_period;
    saw_divider_next = saw_divider;
    saw_step_next    = saw_step;
    saw_sum_next     = saw_sum;
    saw_rate_next    = saw_rate;
    saw_level_next   = saw_level;
    if (cmd_saw.wr0) begin
      saw_rate_next = cmd_saw.data[5:0];
    end
    if (cmd_saw.wr1) begin
      saw_period_next = {saw_period[11:8], cmd_saw.data};
    end
    if (cmd_saw.wr2) begin
      saw_enable_next = cmd_saw.data[7];
      saw_period_next = {cmd_saw.data[3:0], saw_period[7:0]};
    end
    if (cmd_saw.tick && saw_enable) begin
      if (saw_divider >= saw_period) begin
        if (saw_step_inc == psaw_pkg::SAW_WRAP_STEP) begin
          saw_step_next = '0;
          saw_sum_next  = '0;
        end else begin
          saw_step_next = saw_step_inc;
          if (saw_step_inc[0]) begin
            saw_sum_next = saw_sum + {3'b000, saw_rate};
          end
        end
        saw_level_next   = saw_sum_next[8:3];
        saw_divider_next = '0;
      end else begin
        saw_divider_next = saw_divider + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saw_enable  <= 1'b0;
      saw_period  <= psaw_pkg::PERIOD_RESET;
      saw_divider <= '0;
      saw_step    <= '0;
      saw_sum     <= '0;
      saw_rate    <= '0;
      saw_level   <= '0;
    end else if (accept) begin
      saw_enable  <= saw_enable_next;
      saw_period  <= saw_period_next;
      saw_divider <= saw_divider_next;
      saw_step    <= saw_step_next;
      saw_sum     <= saw_sum_next;
      saw_rate    <= saw_rate_next;
      saw_level   <= saw_level_next;
    end
  end

  assign saw_contrib = saw_enable_next ? saw_level_next : 6'd0;
  assign level_sum   = {3'b000, p0_level} + {3'b000, p1_level} + {1'b0, saw_contrib};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_level <= '0;
      out_irq   <= 1'b0;
    end else if (accept) begin
      out_level <= level_sum;
      out_irq   <= pending_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.audio_level = out_level;
  assign out_ch.irq_line    = out_irq;

  `PSAW_ASSERT_NEXT(a_result_follows, accept, out_valid)
  `PSAW_ASSERT_NOW(a_full_blocks_input, out_valid && !out_ch.ready, !in_ch.ready)
  `PSAW_ASSERT_NEXT(a_low_write_no_effect, low_write, $stable(out_level) && $stable(out_irq))

endmodule

// File: hw/rtl/psaw_pulse.sv
// One pulse channel: duty/volume/period registers, divider and step sequencer.
// Depends on psaw_pkg.
`timescale 1ns / 1ps

module psaw_pulse (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  psaw_pkg::chan_cmd_t cmd,
  output logic [3:0]          level_next_out
);

  logic        enable, enable_next;
  logic [11:0] period, period_next;
  logic [11:0] divider, divider_next;
  logic [3:0]  step, step_next;
  logic [3:0]  volume, volume_next;
  logic [15:0] pattern, pattern_next;
  logic [3:0]  level, level_next;

  always_comb begin
    enable_next  = enable;
    period_next  = period;
    divider_next = divider;
    step_next    = step;
    volume_next  = volume;
    pattern_next = pattern;
    level_next   = level;
    if (cmd.wr0) begin
      // bit 7: constant high; else d+1 high steps from the top
      if (cmd.data[7]) begin
        pattern_next = 16'hFFFF;
      end else begin
        pattern_next = 16'($signed(16'h8000) >>> cmd.data[6:4]);
      end
      volume_next = cmd.data[3:0];
    end
    if (cmd.wr1) begin
      period_next = {period[11:8], cmd.data};
    end
    if (cmd.wr2) begin
      enable_next = cmd.data[7];
      period_next = {cmd.data[3:0], period[7:0]};
    end
    if (cmd.tick && enable) begin
      if (divider >= period) begin
        level_next   = pattern[step] ? volume : 4'd0;
        divider_next = '0;
        step_next    = step - 4'd1;
      end else begin
        divider_next = divider + 12'd1;
      end
    end
  end

  assign level_next_out = enable_next ? level_next : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      period  <= psaw_pkg::PERIOD_RESET;
      divider <= '0;
      step    <= '0;
      volume  <= '0;
      pattern <= psaw_pkg::DUTY_RESET;
      level   <= '0;
    end else if (accept) begin
      enable  <= enable_next;
      period  <= period_next;
      divider <= divider_next;
      step    <= step_next;
      volume  <= volume_next;
      pattern <= pattern_next;
      level   <= level_next;
    end
  end

endmodule

// File: hw/rtl/psaw_irq.sv
// IRQ counter with scanline prescaler or per-cycle clocking.
// Depends on psaw_pkg.
`timescale 1ns / 1ps

module psaw_irq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  psaw_pkg::chan_cmd_t cmd,
  output logic                pending_next_out
);

  logic [7:0] reload, reload_next;
  logic [7:0] count, count_next;
  logic       pending, pending_next;
  logic       enable_after_ack, enable_after_ack_next;
  logic       enabled, enabled_next;
  logic       cycle_mode, cycle_mode_next;
  logic [8:0] prescaler, prescaler_next;
  logic       clock_count;

  always_comb begin
    reload_next           = reload;
    count_next            = count;
    pending_next          = pending;
    enable_after_ack_next = enable_after_ack;
    enabled_next          = enabled;
    cycle_mode_next       = cycle_mode;
    prescaler_next        = prescaler;
    clock_count           = 1'b0;
    if (cmd.wr0) begin
      reload_next = cmd.data;
    end
    if (cmd.wr1) begin
      enable_after_ack_next = cmd.data[0];
      enabled_next          = cmd.data[1];
      cycle_mode_next       = cmd.data[2];
      if (cmd.data[1]) begin
        count_next     = reload;
        prescaler_next = psaw_pkg::LINE_CYCLES;
      end
      pending_next = 1'b0;
    end
    if (cmd.wr2) begin
      pending_next = 1'b0;
      enabled_next = enable_after_ack;
    end
    if (cmd.tick && enabled) begin
      if (cycle_mode) begin
        clock_count = 1'b1;
      end else if (prescaler <= psaw_pkg::PRESCALE_STEP) begin
        // crossed zero: wrap by one scanline
        prescaler_next = prescaler + (psaw_pkg::LINE_CYCLES - psaw_pkg::PRESCALE_STEP);
        clock_count    = 1'b1;
      end else begin
        prescaler_next = prescaler - psaw_pkg::PRESCALE_STEP;
      end
    end
    if (clock_count) begin
      if (count == psaw_pkg::IRQ_COUNT_TOP) begin
        pending_next = 1'b1;
        count_next   = reload;
      end else begin
        count_next = count + 8'd1;
      end
    end
  end

  assign pending_next_out = pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload           <= '0;
      count            <= '0;
      pending          <= 1'b0;
      enable_after_ack <= 1'b0;
      enabled          <= 1'b0;
      cycle_mode       <= 1'b0;
      prescaler        <= psaw_pkg::LINE_CYCLES;
    end else if (accept) begin
      reload           <= reload_next;
      count            <= count_next;
      pending          <= pending_next;
      enable_after_ack <= enable_after_ack_next;
      enabled          <= enabled_next;
      cycle_mode       <= cycle_mode_next;
      prescaler        <= prescaler_next;
    end
  end

endmodule
